FILE: rtl/byte_record_deque_defines.svh
// Assertion macros for the byte record deque.
`ifndef BYTE_RECORD_DEQUE_DEFINES_SVH
`define BYTE_RECORD_DEQUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BRDQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BRDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/brdq_pkg.sv
// Package: types and constants for the byte record deque.
package brdq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int MAX_BYTES_DEF = 64;
    localparam int BYTE_W        = 8;
    localparam int COUNT_W       = 5;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_TRUNC = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_FRONT = 2'd1,
        PEND_BACK  = 2'd2,
        PEND_DROP  = 2'd3
    } pend_t;

    typedef enum logic [1:0] {
        FSM_IDLE   = 2'd0,
        FSM_LEN    = 2'd1,
        FSM_STREAM = 2'd2
    } fsm_t;

endpackage

FILE: rtl/brdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module brdq_ram #(
    parameter int WIDTH = brdq_pkg::BYTE_W,
    parameter int DEPTH = brdq_pkg::DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/byte_record_deque.sv
// Top level: double-ended queue of variable-length byte records.
//
// Holds up to DEPTH records of up to MAX_BYTES bytes in a ring of slots; the
// bytes sit in one RAM (slot * MAX_BYTES + offset), the lengths in a second.
// Push items (at most one byte each, tlast ends the record) and clear items
// each answer with one status transfer. A pop is accepted, then reads the
// record length, then streams one byte per cycle, while the result side does
// not stall, from the single read port of the byte RAM; the next item can be
// taken only once the record is out. An empty pop and a zero-length pop each
// answer with one transfer. Only one item is worked on at a time. Both RAMs
// need no clearing after reset: a slot is always written before it can be
// popped. Opcodes five to seven are taken and dropped.
module byte_record_deque #(
    parameter int DEPTH     = brdq_pkg::DEPTH_DEF,
    parameter int MAX_BYTES = brdq_pkg::MAX_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_value[7:0]
    input  logic [3:0]  s_tuser,   // opcode[2:0], byte_present[3]
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_byte[7:0], record_count[12:8], zero[15:13]
    output logic [2:0]  m_tuser,   // out_present[0], status[2:1]
    output logic        m_tlast    // out_last
);

    `include "byte_record_deque_defines.svh"

    localparam int SW  = $clog2(DEPTH);
    localparam int BAW = $clog2(DEPTH * MAX_BYTES);
    localparam int LW  = $clog2(MAX_BYTES + 1);
    localparam int CW  = $clog2(DEPTH + 1);

    brdq_pkg::fsm_t    state_reg, state_next;
    brdq_pkg::pend_t   pend_reg, pend_next, pend_eff;
    brdq_pkg::opcode_t op;
    brdq_pkg::status_t push_status;

    logic [SW-1:0]  front_reg, front_next, back_reg, back_next;
    logic [SW-1:0]  front_dec, front_inc, back_dec, back_inc;
    logic [SW-1:0]  slot_reg, slot_next, push_slot;
    logic [CW-1:0]  held_reg, held_next;
    logic [LW-1:0]  fill_reg, fill_next, fill_eff, fill_add;
    logic [LW-1:0]  len_reg, len_next, idx_reg, idx_next;
    logic           d_vld_reg, d_vld_next, d_last_reg, d_last_next;
    logic           out_vld_reg, out_vld_next;

    logic [7:0]     out_byte_reg, out_byte_next;
    logic           out_present_reg, out_present_next;
    logic           out_last_reg, out_last_next;
    logic [1:0]     out_status_reg, out_status_next;
    logic [4:0]     out_count_reg, out_count_next;

    logic           accept, out_free, out_load, rd_issue, d_load;

    logic           byte_wr_en, byte_rd_en, len_wr_en, len_rd_en;
    logic [BAW-1:0] byte_wr_addr, byte_rd_addr;
    logic [SW-1:0]  len_wr_addr, len_rd_addr;
    logic [7:0]     byte_rd_data;
    logic [LW-1:0]  len_wr_data, len_rd_data;

    brdq_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH * MAX_BYTES)
    ) u_byte_ram (
        .clk     (clk),
        .wr_en   (byte_wr_en),
        .wr_addr (byte_wr_addr),
        .wr_data (s_tdata),
        .rd_en   (byte_rd_en),
        .rd_addr (byte_rd_addr),
        .rd_data (byte_rd_data)
    );

    brdq_ram #(
        .WIDTH (LW),
        .DEPTH (DEPTH)
    ) u_len_ram (
        .clk     (clk),
        .wr_en   (len_wr_en),
        .wr_addr (len_wr_addr),
        .wr_data (len_wr_data),
        .rd_en   (len_rd_en),
        .rd_addr (len_rd_addr),
        .rd_data (len_rd_data)
    );

    assign op        = brdq_pkg::opcode_t'(s_tuser[2:0]);
    assign out_free  = !out_vld_reg || m_tready;
    assign s_tready  = (state_reg == brdq_pkg::FSM_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;

    assign front_dec = (front_reg == '0) ? SW'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == SW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign back_dec  = (back_reg == '0) ? SW'(DEPTH - 1) : back_reg - 1'b1;
    assign back_inc  = (back_reg == SW'(DEPTH - 1)) ? '0 : back_reg + 1'b1;

    // push bookkeeping: the first item of a record picks the end or drops it
    always_comb
    begin
        if (pend_reg == brdq_pkg::PEND_NONE)
        begin
            fill_eff = '0;
            if (held_reg >= CW'(DEPTH))
            begin
                pend_eff = brdq_pkg::PEND_DROP;
            end
            else if (op == brdq_pkg::OP_PUSH_FRONT)
            begin
                pend_eff = brdq_pkg::PEND_FRONT;
            end
            else
            begin
                pend_eff = brdq_pkg::PEND_BACK;
            end
        end
        else
        begin
            fill_eff = fill_reg;
            pend_eff = pend_reg;
        end
        push_slot   = (pend_eff == brdq_pkg::PEND_FRONT) ? front_dec : back_reg;
        push_status = brdq_pkg::ST_OK;
        fill_add    = fill_eff;
        if (pend_eff == brdq_pkg::PEND_DROP)
        begin
            push_status = brdq_pkg::ST_FULL;
        end
        else if (s_tuser[3])
        begin
            if (fill_eff < LW'(MAX_BYTES))
            begin
                fill_add = fill_eff + 1'b1;
            end
            else
            begin
                push_status = brdq_pkg::ST_TRUNC;
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        pend_next        = pend_reg;
        fill_next        = fill_reg;
        front_next       = front_reg;
        back_next        = back_reg;
        held_next        = held_reg;
        slot_next        = slot_reg;
        len_next         = len_reg;
        idx_next         = idx_reg;
        d_vld_next       = d_vld_reg;
        d_last_next      = d_last_reg;
        out_load         = 1'b0;
        out_byte_next    = out_byte_reg;
        out_present_next = out_present_reg;
        out_last_next    = out_last_reg;
        out_status_next  = out_status_reg;
        out_count_next   = out_count_reg;
        byte_wr_en       = 1'b0;
        byte_wr_addr     = BAW'(BAW'(push_slot) * BAW'(MAX_BYTES)) + BAW'(fill_eff);
        len_wr_en        = 1'b0;
        len_wr_addr      = push_slot;
        len_wr_data      = fill_add;
        len_rd_en        = 1'b0;
        len_rd_addr      = (op == brdq_pkg::OP_POP_FRONT) ? front_reg : back_dec;
        d_load           = d_vld_reg && out_free;
        rd_issue         = 1'b0;
        byte_rd_en       = 1'b0;
        byte_rd_addr     = BAW'(BAW'(slot_reg) * BAW'(MAX_BYTES)) + BAW'(idx_reg);

        unique case (state_reg)
            brdq_pkg::FSM_IDLE:
            begin
                if (accept)
                begin
                    unique case (op) inside
                        brdq_pkg::OP_PUSH_FRONT, brdq_pkg::OP_PUSH_BACK:
                        begin
                            byte_wr_en = (pend_eff != brdq_pkg::PEND_DROP) && s_tuser[3]
                                         && (fill_eff < LW'(MAX_BYTES));
                            if (s_tlast)
                            begin
                                if (pend_eff != brdq_pkg::PEND_DROP)
                                begin
                                    len_wr_en = 1'b1;
                                    held_next = held_reg + 1'b1;
                                    if (pend_eff == brdq_pkg::PEND_FRONT)
                                    begin
                                        front_next = push_slot;
                                    end
                                    else
                                    begin
                                        back_next = back_inc;
                                    end
                                end
                                pend_next = brdq_pkg::PEND_NONE;
                                fill_next = '0;
                            end
                            else
                            begin
                                pend_next = pend_eff;
                                fill_next = fill_add;
                            end
                            out_load        = 1'b1;
                            out_status_next = push_status;
                        end
                        brdq_pkg::OP_POP_FRONT, brdq_pkg::OP_POP_BACK:
                        begin
                            pend_next = brdq_pkg::PEND_NONE;
                            fill_next = '0;
                            if (held_reg == '0)
                            begin
                                out_load        = 1'b1;
                                out_status_next = brdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                len_rd_en = 1'b1;
                                slot_next = len_rd_addr;
                                held_next = held_reg - 1'b1;
                                if (op == brdq_pkg::OP_POP_FRONT)
                                begin
                                    front_next = front_inc;
                                end
                                else
                                begin
                                    back_next = back_dec;
                                end
                                state_next = brdq_pkg::FSM_LEN;
                            end
                        end
                        brdq_pkg::OP_CLEAR:
                        begin
                            pend_next       = brdq_pkg::PEND_NONE;
                            fill_next       = '0;
                            held_next       = '0;
                            front_next      = '0;
                            back_next       = '0;
                            out_load        = 1'b1;
                            out_status_next = brdq_pkg::ST_OK;
                        end
                        default:
                        begin
                        end
                    endcase
                    out_byte_next    = '0;
                    out_present_next = 1'b0;
                    out_last_next    = 1'b1;
                    out_count_next   = 5'({5'd0, held_next});
                end
            end
            brdq_pkg::FSM_LEN:
            begin
                if (len_rd_data == '0)
                begin
                    if (out_free)
                    begin
                        out_load         = 1'b1;
                        out_byte_next    = '0;
                        out_present_next = 1'b0;
                        out_last_next    = 1'b1;
                        out_status_next  = brdq_pkg::ST_OK;
                        out_count_next   = 5'({5'd0, held_reg});
                        state_next       = brdq_pkg::FSM_IDLE;
                    end
                end
                else
                begin
                    len_next   = len_rd_data;
                    idx_next   = '0;
                    d_vld_next = 1'b0;
                    state_next = brdq_pkg::FSM_STREAM;
                end
            end
            brdq_pkg::FSM_STREAM:
            begin
                rd_issue   = (idx_reg != len_reg) && (!d_vld_reg || d_load);
                byte_rd_en = rd_issue;
                if (d_load)
                begin
                    out_load         = 1'b1;
                    out_byte_next    = byte_rd_data;
                    out_present_next = 1'b1;
                    out_last_next    = d_last_reg;
                    out_status_next  = brdq_pkg::ST_OK;
                    out_count_next   = 5'({5'd0, held_reg});
                end
                if (rd_issue)
                begin
                    idx_next    = idx_reg + 1'b1;
                    d_vld_next  = 1'b1;
                    d_last_next = (idx_next == len_reg);
                end
                else if (d_load)
                begin
                    d_vld_next = 1'b0;
                end
                if ((idx_reg == len_reg) && !d_vld_next)
                begin
                    state_next = brdq_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = brdq_pkg::FSM_IDLE;
            end
        endcase

        out_vld_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= brdq_pkg::FSM_IDLE;
            pend_reg    <= brdq_pkg::PEND_NONE;
            fill_reg    <= '0;
            front_reg   <= '0;
            back_reg    <= '0;
            held_reg    <= '0;
            slot_reg    <= '0;
            len_reg     <= '0;
            idx_reg     <= '0;
            d_vld_reg   <= 1'b0;
            d_last_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            fill_reg    <= fill_next;
            front_reg   <= front_next;
            back_reg    <= back_next;
            held_reg    <= held_next;
            slot_reg    <= slot_next;
            len_reg     <= len_next;
            idx_reg     <= idx_next;
            d_vld_reg   <= d_vld_next;
            d_last_reg  <= d_last_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg    <= out_byte_next;
        out_present_reg <= out_present_next;
        out_last_reg    <= out_last_next;
        out_status_reg  <= out_status_next;
        out_count_reg   <= out_count_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'd0, out_count_reg, out_byte_reg};
    assign m_tuser  = {out_status_reg, out_present_reg};
    assign m_tlast  = out_last_reg;

    `BRDQ_ASSERT_NOW(a_held_bound, 1'b1, held_reg <= CW'(DEPTH),
        "record count above capacity")
    `BRDQ_ASSERT_NOW(a_ready_idle, s_tready, state_reg == brdq_pkg::FSM_IDLE,
        "input taken while a pop is in flight")
    `BRDQ_ASSERT_NOW(a_data_stream, d_vld_reg, state_reg == brdq_pkg::FSM_STREAM,
        "read data pending outside pop streaming")
    `BRDQ_ASSERT_NOW(a_idx_bound, state_reg == brdq_pkg::FSM_STREAM,
        idx_reg <= len_reg, "byte index past record length")
    `BRDQ_ASSERT_NEXT(a_pop_dec,
        accept && (held_reg != '0)
            && ((op == brdq_pkg::OP_POP_FRONT) || (op == brdq_pkg::OP_POP_BACK)),
        held_reg == $past(held_reg) - 1'b1, "pop did not remove one record")

endmodule

FILE: test/brdq_checker.sv
// Checker for the byte record deque: predicts every result transfer and compares it.
module brdq_checker
    import brdq_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int MAX_BYTES = MAX_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_value[7:0]
    input  logic [3:0]  s_tuser,   // opcode[2:0], byte_present[3]
    input  logic        s_tlast,   // last_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // out_byte[7:0], record_count[12:8], zero[15:13]
    input  logic [2:0]  m_tuser,   // out_present[0], status[2:1]
    input  logic        m_tlast,   // out_last
    output int          mismatches,
    output int          outstanding,
    output int          replies_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
        status_t    status;
        logic [4:0] count;
    } reply_t;

    reply_t      expected_replies[$];

    logic [7:0]  stored_bytes[DEPTH * MAX_BYTES];
    logic [6:0]  stored_lengths[DEPTH];
    int unsigned front_pos;
    int unsigned back_pos;
    int unsigned held;
    int unsigned filled;
    pend_t       pending_push;

    function automatic int unsigned push_slot();
        if (pending_push == PEND_FRONT)
            return (front_pos + DEPTH - 1) % DEPTH;
        return back_pos;
    endfunction

    task automatic predict_replies(input logic [2:0] op, input logic [7:0] value,
                                   input logic present, input logic last_flag);
        reply_t      r;
        int unsigned slot;
        int unsigned len;
        int unsigned i;
        r = '0;
        r.last = 1'b1;
        r.status = ST_OK;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (pending_push == PEND_NONE)
                begin
                    filled = 0;
                    if (held >= DEPTH)
                        pending_push = PEND_DROP;
                    else if (op == OP_PUSH_FRONT)
                        pending_push = PEND_FRONT;
                    else
                        pending_push = PEND_BACK;
                end
                if (pending_push == PEND_DROP)
                    r.status = ST_FULL;
                else if (present)
                begin
                    if (filled < MAX_BYTES)
                    begin
                        stored_bytes[push_slot() * MAX_BYTES + filled] = value;
                        filled++;
                    end
                    else
                        r.status = ST_TRUNC;
                end
                if (last_flag)
                begin
                    if (pending_push != PEND_DROP)
                    begin
                        slot = push_slot();
                        stored_lengths[slot] = 7'(filled);
                        if (pending_push == PEND_FRONT)
                            front_pos = slot;
                        else
                            back_pos = (back_pos + 1) % DEPTH;
                        held++;
                    end
                    pending_push = PEND_NONE;
                    filled = 0;
                end
                r.count = 5'(held);
                expected_replies.push_back(r);
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                pending_push = PEND_NONE;
                filled = 0;
                if (held == 0)
                begin
                    r.status = ST_EMPTY;
                    expected_replies.push_back(r);
                end
                else
                begin
                    if (op == OP_POP_FRONT)
                    begin
                        slot = front_pos;
                        front_pos = (front_pos + 1) % DEPTH;
                    end
                    else
                    begin
                        back_pos = (back_pos + DEPTH - 1) % DEPTH;
                        slot = back_pos;
                    end
                    held--;
                    r.count = 5'(held);
                    len = 32'(stored_lengths[slot]);
                    if (len > MAX_BYTES)
                        len = MAX_BYTES;
                    if (len == 0)
                        expected_replies.push_back(r);
                    else
                        for (i = 0; i < len; i++)
                        begin
                            r.data = stored_bytes[slot * MAX_BYTES + i];
                            r.present = 1'b1;
                            r.last = (i + 1 == len);
                            expected_replies.push_back(r);
                        end
                end
            end
            OP_CLEAR:
            begin
                pending_push = PEND_NONE;
                filled = 0;
                held = 0;
                front_pos = 0;
                back_pos = 0;
                expected_replies.push_back(r);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic flag_mismatch(input string field, input int want, input int seen);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, seen);
        mismatches++;
    endtask

    task automatic check_reply();
        reply_t got;
        reply_t want;
        got.data = m_tdata[7:0];
        got.count = m_tdata[12:8];
        got.present = m_tuser[0];
        got.status = status_t'(m_tuser[2:1]);
        got.last = m_tlast;
        if (expected_replies.size() == 0)
        begin
            $display("%0t: unexpected transfer, expected none, got byte %0d present %0d",
                     $time, got.data, got.present);
            $display("    last %0d status %0d count %0d",
                     got.last, int'(got.status), got.count);
            mismatches++;
            return;
        end
        want = expected_replies.pop_front();
        replies_checked++;
        if (got.data !== want.data)
            flag_mismatch("out_byte", int'(want.data), int'(got.data));
        if (got.present !== want.present)
            flag_mismatch("out_present", int'(want.present), int'(got.present));
        if (got.last !== want.last)
            flag_mismatch("out_last", int'(want.last), int'(got.last));
        if (got.status !== want.status)
            flag_mismatch("status", int'(want.status), int'(got.status));
        if (got.count !== want.count)
            flag_mismatch("record_count", int'(want.count), int'(got.count));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_replies.delete();
            front_pos = 0;
            back_pos = 0;
            held = 0;
            filled = 0;
            pending_push = PEND_NONE;
            outstanding = 0;
            mismatches = 0;
            replies_checked = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_replies(s_tuser[2:0], s_tdata, s_tuser[3], s_tlast);
            if (m_tvalid && m_tready)
                check_reply();
            outstanding = expected_replies.size();
        end
    end

endmodule

FILE: test/tb.sv
// Testbench top for the byte record deque: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import brdq_pkg::*;

    localparam int          ITEM_TARGET    = 430;
    localparam int          TAIL_CYCLES    = 80;
    localparam int          TIMEOUT_NS     = 12_000_000;
    localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // byte_value[7:0]
    logic [3:0]  s_tuser;   // opcode[2:0], byte_present[3]
    logic        s_tlast;   // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // out_byte[7:0], record_count[12:8], zero[15:13]
    logic [2:0]  m_tuser;   // out_present[0], status[2:1]
    logic        m_tlast;   // out_last

    int          mismatches;
    int          outstanding;
    int          replies_checked;
    int          items_sent;
    logic        no_idle;

    byte_record_deque u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    brdq_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .replies_checked (replies_checked)
    );

    initial
        clk = 1'b0;

    always #6 clk = ~clk;

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

    function automatic logic [2:0] pick_push();
        return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    endfunction

    function automatic logic [2:0] pick_pop();
        return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic int record_length();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return $urandom_range(0, 8);
        if (r < 18)
            return $urandom_range(9, 40);
        return $urandom_range(56, MAX_BYTES_DEF + 6);
    endfunction

    task automatic offer_item(input logic [2:0] op, input logic [7:0] value,
                              input logic present, input logic last_flag);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= {present, op};
        s_tlast  <= last_flag;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op <= OP_CLEAR)
            items_sent++;
    endtask

    // later items may flip the push opcode; the record keeps its first end
    task automatic push_record(input logic [2:0] first_op, input int nbytes);
        int         i;
        logic [2:0] op;
        logic       end_on_filler;
        if (nbytes == 0)
        begin
            offer_item(first_op, rand_byte(), 1'b0, 1'b1);
            return;
        end
        end_on_filler = ($urandom_range(0, 7) == 0);
        for (i = 0; i < nbytes; i++)
        begin
            op = first_op;
            if (i != 0 && $urandom_range(0, 7) == 0)
                op = (first_op == OP_PUSH_FRONT) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            if ($urandom_range(0, 15) == 0)
                offer_item(op, rand_byte(), 1'b0, 1'b0);
            offer_item(op, rand_byte(), 1'b1, (i == nbytes - 1) && !end_on_filler);
        end
        if (end_on_filler)
            offer_item(first_op, rand_byte(), 1'b0, 1'b1);
    endtask

    task automatic pop_record();
        offer_item(pick_pop(), rand_byte(), rand_bit(), rand_bit());
    endtask

    task automatic clear_all();
        offer_item(OP_CLEAR, rand_byte(), rand_bit(), rand_bit());
    endtask

    task automatic broken_push();
        int k;
        int n;
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++)
            offer_item(pick_push(), rand_byte(), rand_bit(), 1'b0);
        if ($urandom_range(0, 2) == 0)
            clear_all();
        else
            pop_record();
    endtask

    task automatic fill_until_drop();
        int k;
        for (k = 0; k < 17; k++)
            push_record(pick_push(), $urandom_range(0, 2));
        push_record(pick_push(), 3);
        broken_push();
        for (k = 0; k < 3; k++)
            pop_record();
    endtask

    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!no_idle && $urandom_range(0, 8) != 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin
        int round;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        s_tlast    = 1'b0;
        rst_n      = 1'b0;
        items_sent = 0;
        no_idle    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // empty pops and clear, zero-length record, both ends, byte extremes
        offer_item(OP_POP_FRONT, 8'h00, 1'b0, 1'b0);
        offer_item(OP_POP_BACK, 8'hFF, 1'b1, 1'b1);
        offer_item(OP_CLEAR, 8'h00, 1'b0, 1'b0);
        offer_item(OP_PUSH_BACK, 8'h00, 1'b0, 1'b1);
        offer_item(OP_POP_FRONT, 8'h00, 1'b0, 1'b0);
        offer_item(OP_PUSH_FRONT, 8'hFF, 1'b1, 1'b1);
        offer_item(OP_PUSH_BACK, 8'h00, 1'b1, 1'b1);
        offer_item(OP_PUSH_FRONT, 8'hA5, 1'b1, 1'b0);
        offer_item(OP_PUSH_BACK, 8'h5A, 1'b1, 1'b1);
        offer_item(OP_POP_BACK, 8'h00, 1'b0, 1'b0);
        offer_item(OP_POP_FRONT, 8'h00, 1'b0, 1'b0);
        offer_item(OP_POP_FRONT, 8'h00, 1'b0, 1'b0);
        offer_item(OP_PUSH_BACK, 8'h81, 1'b1, 1'b0);
        offer_item(OP_PUSH_BACK, 8'h7E, 1'b0, 1'b1);
        offer_item(OP_POP_BACK, 8'h00, 1'b0, 1'b0);
        offer_item(OP_POP_FRONT, 8'h00, 1'b0, 1'b0);
        // pop and clear in the middle of a push
        offer_item(OP_PUSH_FRONT, 8'h3C, 1'b1, 1'b0);
        offer_item(OP_POP_BACK, 8'h00, 1'b0, 1'b0);
        offer_item(OP_PUSH_BACK, 8'hC3, 1'b1, 1'b0);
        offer_item(OP_CLEAR, 8'hFF, 1'b1, 1'b1);
        offer_item(3'(OP_SPARE_FIRST + 2), 8'hFF, 1'b1, 1'b1);
        offer_item(OP_POP_FRONT, 8'h00, 1'b0, 1'b0);

        round = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 24) == 0)
                no_idle = !no_idle;
            if (round == 0 || round % 60 == 30)
                fill_until_drop();
            else if (round == 1)
            begin
                push_record(OP_PUSH_BACK, MAX_BYTES_DEF);
                push_record(OP_PUSH_FRONT, MAX_BYTES_DEF + 2);
                pop_record();
                pop_record();
            end
            else
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
                        push_record(pick_push(), record_length());
                    10, 11, 12, 13, 14, 15, 16:
                        pop_record();
                    17:
                        broken_push();
                    18:
                        offer_item(3'(OP_SPARE_FIRST + $urandom_range(0, 2)),
                                   rand_byte(), rand_bit(), rand_bit());
                    default:
                        if ($urandom_range(0, 2) == 0)
                            clear_all();
                        else
                            pop_record();
                endcase
            round++;
        end
        s_tvalid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d deque operations: pushes at both ends, pops, clears,", items_sent);
        $display("full and overlong records; checked %0d result transfers under stalls.",
                 replies_checked);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: byte_record_deque.f
+incdir+rtl
rtl/brdq_pkg.sv
rtl/brdq_ram.sv
rtl/byte_record_deque.sv
test/brdq_checker.sv
test/tb.sv
